// ===== hw/rtl/sv39_page_table_walker_macros.svh =====
// ----------------------------------------------------------------------------
// sv39_page_table_walker_macros
// Assertion helpers used by the walker controller.
// ----------------------------------------------------------------------------
`ifndef SV39_PAGE_TABLE_WALKER_MACROS_SVH
`define SV39_PAGE_TABLE_WALKER_MACROS_SVH

// Same-cycle implication, disabled in reset
`define SV39_ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("sv39 walker: same-cycle check failed");

// Next-cycle implication, disabled in reset
`define SV39_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("sv39 walker: next-cycle check failed");

`endif

// ===== hw/rtl/sv39ptw_pkg.sv =====
// ----------------------------------------------------------------------------
// sv39ptw_pkg
// Types, codes and helpers for the Sv39 page table walker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sv39ptw_pkg;

    localparam int unsigned PPN_W   = 44;
    localparam int unsigned VA_W    = 39;
    localparam int unsigned PA_W    = 56;
    localparam int unsigned PTE_W   = 64;
    localparam int unsigned PGOFF_W = 12;
    localparam int unsigned VPN_W   = 9;
    localparam int unsigned LVL_W   = 2;

    // Input word kinds
    localparam logic CMD_TRANSLATE = 1'b0;
    localparam logic CMD_RESPONSE  = 1'b1;

    // Result word kinds
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Table levels
    localparam logic [LVL_W-1:0] LVL_0 = 2'd0;
    localparam logic [LVL_W-1:0] LVL_1 = 2'd1;
    localparam logic [LVL_W-1:0] LVL_2 = 2'd2;

    typedef struct packed {
        logic             cmd;
        logic [VA_W-1:0]  virt_addr;
        logic [PTE_W-1:0] mem_data;
    } in_word_t;

    typedef struct packed {
        logic             out_kind;
        logic [PA_W-1:0]  read_addr;
        logic             found;
        logic [PTE_W-1:0] leaf_entry;
        logic [PA_W-1:0]  leaf_entry_addr;
    } out_word_t;

    // Controller to datapath
    typedef struct packed {
        logic             start;
        logic             step;
        logic             done_hit;
        logic             done_miss;
        logic [LVL_W-1:0] next_level;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_resp;
        logic pte_valid;
    } dp_status_t;

    // Byte offset of the entry for one level inside its table
    function automatic logic [PGOFF_W-1:0] entry_offset(
        input logic [VA_W-1:0]  va,
        input logic [LVL_W-1:0] level
    );
        logic [VPN_W-1:0] vpn;
        case (level)
            LVL_0:   vpn = va[20:12];
            LVL_1:   vpn = va[29:21];
            LVL_2:   vpn = va[38:30];
            default: vpn = '0;
        endcase
        return {vpn, 3'b000};
    endfunction

endpackage

// ===== hw/rtl/sv39_page_table_walker.sv =====
// ----------------------------------------------------------------------------
// sv39_page_table_walker: three-level Sv39 table walk over a memory port.
// Result: a result word is registered and presented in the cycle after its input word is taken.
// Throughput: 1 input word per cycle, set by the single result register: a new
//   word is taken only while that register is empty or being read out, so a
//   held result word stalls the input; a walk spans up to three read round trips.
// Reset: async active-low; idle, root table page number cleared to 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sv39_page_table_walker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sv39ptw_pkg::PPN_W-1:0]   cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  sv39ptw_pkg::in_word_t           in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output sv39ptw_pkg::out_word_t          out_data
);

    sv39ptw_pkg::dp_cmd_t    cmd;
    sv39ptw_pkg::dp_status_t status;
    logic                    cfg_wr;

    // Register writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    sv39ptw_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    sv39ptw_dp u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr   (cfg_wr),
        .cfg_data (cfg_data),
        .in_data  (in_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (out_data)
    );

endmodule

// ===== hw/rtl/sv39ptw_dp.sv =====
// ----------------------------------------------------------------------------
// sv39ptw_dp
// Walker datapath: root register, walk address state and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sv39ptw_dp
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr,
    input  logic [sv39ptw_pkg::PPN_W-1:0]   cfg_data,
    input  sv39ptw_pkg::in_word_t           in_data,
    input  sv39ptw_pkg::dp_cmd_t            cmd,
    output sv39ptw_pkg::dp_status_t         status,
    output sv39ptw_pkg::out_word_t          out_data
);

    logic [sv39ptw_pkg::PPN_W-1:0] root_ppn_reg;
    logic [sv39ptw_pkg::VA_W-1:0]  vaddr_reg;
    logic [sv39ptw_pkg::PA_W-1:0]  entry_addr_reg;
    logic [sv39ptw_pkg::PA_W-1:0]  entry_addr_next;
    sv39ptw_pkg::out_word_t        out_reg;
    sv39ptw_pkg::out_word_t        out_next;
    logic [sv39ptw_pkg::PA_W-1:0]  base_addr;
    logic [sv39ptw_pkg::PGOFF_W-1:0] offset;

    // Report the word kind and the entry valid bit
    assign status.is_resp   = (in_data.cmd == sv39ptw_pkg::CMD_RESPONSE);
    assign status.pte_valid = in_data.mem_data[0];

    // Pick table base and entry offset for the next read
    always_comb
    begin
        if (cmd.start)
        begin
            base_addr = {root_ppn_reg, {sv39ptw_pkg::PGOFF_W{1'b0}}};
            offset    = sv39ptw_pkg::entry_offset(in_data.virt_addr, sv39ptw_pkg::LVL_2);
        end
        else
        begin
            base_addr = {in_data.mem_data[53:10], {sv39ptw_pkg::PGOFF_W{1'b0}}};
            offset    = sv39ptw_pkg::entry_offset(vaddr_reg, cmd.next_level);
        end
        entry_addr_next = base_addr + sv39ptw_pkg::PA_W'(offset);
    end

    // Build the result word
    always_comb
    begin
        out_next = '0;
        if (cmd.start || cmd.step)
        begin
            out_next.out_kind  = sv39ptw_pkg::KIND_READ;
            out_next.read_addr = entry_addr_next;
        end
        else
        begin
            out_next.out_kind = sv39ptw_pkg::KIND_DONE;
            if (cmd.done_hit)
            begin
                out_next.found           = 1'b1;
                out_next.leaf_entry      = in_data.mem_data;
                out_next.leaf_entry_addr = entry_addr_reg;
            end
        end
    end

    // Hold the root table page number
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            root_ppn_reg <= '0;
        else if (cfg_wr)
            root_ppn_reg <= cfg_data;
    end

    // Track the walk address and load the result word
    always_ff @(posedge clk)
    begin
        if (cmd.start)
            vaddr_reg <= in_data.virt_addr;
        if (cmd.start || cmd.step)
            entry_addr_reg <= entry_addr_next;
        if (cmd.start || cmd.step || cmd.done_hit || cmd.done_miss)
            out_reg <= out_next;
    end

    assign out_data = out_reg;

endmodule

// ===== hw/rtl/sv39ptw_ctrl.sv =====
// ----------------------------------------------------------------------------
// sv39ptw_ctrl
// Walker controller: walk level state machine and channel handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sv39_page_table_walker_macros.svh"

module sv39ptw_ctrl
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  logic                     out_ready,
    input  sv39ptw_pkg::dp_status_t  status,
    output sv39ptw_pkg::dp_cmd_t     cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_L2   = 2'd1;
    localparam logic [1:0] ST_L1   = 2'd2;
    localparam logic [1:0] ST_L0   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       in_fire;
    logic       load_out;

    // Take a new word while the result slot is empty or draining
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // Decode the accepted word against the walk level
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        if (in_fire)
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!status.is_resp)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_L2;
                    end
                end
                ST_L2, ST_L1, ST_L0:
                begin
                    if (status.is_resp)
                    begin
                        if (!status.pte_valid)
                        begin
                            cmd.done_miss = 1'b1;
                            state_next    = ST_IDLE;
                        end
                        else if (state_reg == ST_L0)
                        begin
                            cmd.done_hit = 1'b1;
                            state_next   = ST_IDLE;
                        end
                        else if (state_reg == ST_L2)
                        begin
                            cmd.step       = 1'b1;
                            cmd.next_level = sv39ptw_pkg::LVL_1;
                            state_next     = ST_L1;
                        end
                        else
                        begin
                            cmd.step       = 1'b1;
                            cmd.next_level = sv39ptw_pkg::LVL_0;
                            state_next     = ST_L0;
                        end
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    // Set the result slot on load, drop it when taken
    assign load_out = cmd.start || cmd.step || cmd.done_hit || cmd.done_miss;

    always_comb
    begin
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // Checks
    `SV39_ASSERT_NEXT(a_start_enters_l2, clk, rst_n,
        cmd.start, state_reg == ST_L2)
    `SV39_ASSERT_IMPL(a_hit_only_at_l0, clk, rst_n,
        cmd.done_hit, state_reg == ST_L0)
    `SV39_ASSERT_IMPL(a_idle_drops_response, clk, rst_n,
        in_fire && state_reg == ST_IDLE && status.is_resp, !load_out)
    `SV39_ASSERT_NEXT(a_load_shows_result, clk, rst_n,
        load_out, out_valid_reg)

endmodule

// ===== tb/tb_sv39_page_table_walker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sv39_page_table_walker
// Self-checking bench for the Sv39 table walker. A directed table covers
// idle and busy corner cases, invalid entries at each level and the root
// register extremes. Random walks under several root settings follow. Every
// result word is scored against an in-bench walk predictor or a typed-in result.
// ----------------------------------------------------------------------------

module tb_sv39_page_table_walker;
    import sv39ptw_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int unsigned WALKS_PER_PHASE = 200;
    localparam int unsigned SETTLE_CYCLES   = 4;

    // One row of the directed table: a register write or an input word,
    // optionally with its result typed in.
    typedef struct {
        bit               is_cfg;
        logic [PPN_W-1:0] cfg_value;
        in_word_t         word;
        bit               pinned;
        bit               pin_has;
        out_word_t        pin_word;
    } stim_row_t;

    // Typed-in result attached to an input word, if any
    typedef struct {
        bit        pinned;
        bit        has;
        out_word_t word;
    } pin_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [PPN_W-1:0] cfg_data  = '0;
    logic             in_valid  = 1'b0;
    in_word_t         in_data   = '0;
    logic             out_ready = 1'b0;
    logic             cfg_ready;
    logic             in_ready;
    logic             out_valid;
    out_word_t        out_data;

    // Predictor state
    logic [PPN_W-1:0] root_ppn_m      = '0;
    bit               walk_busy       = 1'b0;
    logic [LVL_W-1:0] walk_lvl        = LVL_2;
    logic [VA_W-1:0]  walk_va         = '0;
    logic [PA_W-1:0]  walk_entry_addr = '0;

    out_word_t   expect_q[$];
    pin_t        pin_q[$];
    stim_row_t   dir_rows[$];
    int unsigned walk_results = 0;
    int          err_count    = 0;
    int unsigned burst_left   = 0;
    int unsigned stall_mode   = 0;
    int unsigned stall_left   = 0;

    sv39_page_table_walker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Byte offset of the entry selected by the VPN slice of one level;
    // a level past the top shifts everything out and selects entry 0
    function automatic logic [PA_W-1:0] vpn_byte_offset(
        input logic [VA_W-1:0]  va,
        input logic [LVL_W-1:0] lvl
    );
        logic [63:0]     shifted;
        logic [PA_W-1:0] off;
        shifted   = {25'b0, va} >> (PGOFF_W + VPN_W * lvl);
        off       = '0;
        off[11:3] = shifted[8:0];
        return off;
    endfunction

    // Advance the predicted walk by one accepted word
    task automatic walk_step(
        input  in_word_t  w,
        output bit        has,
        output out_word_t res
    );
        has = 1'b0;
        res = '0;
        if (w.cmd == CMD_TRANSLATE)
        begin
            // Start a walk at the root, drop requests while busy
            if (!walk_busy)
            begin
                walk_va         = w.virt_addr;
                walk_lvl        = LVL_2;
                walk_entry_addr = {root_ppn_m, 12'b0} + vpn_byte_offset(w.virt_addr, LVL_2);
                walk_busy       = 1'b1;
                has             = 1'b1;
                res.out_kind    = KIND_READ;
                res.read_addr   = walk_entry_addr;
            end
        end
        else if (walk_busy)
        begin
            has = 1'b1;
            if (!w.mem_data[0])
            begin
                walk_busy    = 1'b0;
                walk_lvl     = LVL_2;
                res.out_kind = KIND_DONE;
            end
            else if (walk_lvl == LVL_0)
            begin
                walk_busy           = 1'b0;
                walk_lvl            = LVL_2;
                res.out_kind        = KIND_DONE;
                res.found           = 1'b1;
                res.leaf_entry      = w.mem_data;
                res.leaf_entry_addr = walk_entry_addr;
            end
            else
            begin
                // Follow the pointer; entry bits above the 56-bit space fall off
                walk_lvl        = walk_lvl - 1'b1;
                walk_entry_addr = {w.mem_data[53:10], 12'b0}
                                  + vpn_byte_offset(walk_va, walk_lvl);
                res.out_kind    = KIND_READ;
                res.read_addr   = walk_entry_addr;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("tb: %0t ns mismatch on %s: got %h, expected %h", $time, what, got, want);
        err_count++;
    endtask

    // Track register writes, predict accepted words, score result words
    always @(posedge clk)
    begin : scoreboard
        pin_t      pin;
        bit        has;
        out_word_t res;
        out_word_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                root_ppn_m = cfg_data;
            if (in_valid && in_ready)
            begin
                pin = pin_q.pop_front();
                walk_step(in_data, has, res);
                if (has)
                    walk_results++;
                if (pin.pinned)
                begin
                    has = pin.has;
                    res = pin.word;
                end
                if (has)
                    expect_q.push_back(res);
            end
            if (out_valid && out_ready)
            begin
                if (expect_q.size() == 0)
                    report_mismatch("unexpected result word", 64'(out_data.read_addr), '0);
                else
                begin
                    want = expect_q.pop_front();
                    if (out_data.out_kind !== want.out_kind)
                        report_mismatch("out_kind", 64'(out_data.out_kind),
                                        64'(want.out_kind));
                    if (out_data.read_addr !== want.read_addr)
                        report_mismatch("read_addr", 64'(out_data.read_addr),
                                        64'(want.read_addr));
                    if (out_data.found !== want.found)
                        report_mismatch("found", 64'(out_data.found), 64'(want.found));
                    if (out_data.leaf_entry !== want.leaf_entry)
                        report_mismatch("leaf_entry", out_data.leaf_entry, want.leaf_entry);
                    if (out_data.leaf_entry_addr !== want.leaf_entry_addr)
                        report_mismatch("leaf_entry_addr", 64'(out_data.leaf_entry_addr),
                                        64'(want.leaf_entry_addr));
                end
            end
        end
    end

    // Receiver: switch between free flow, light stalls and heavy stalls
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(20, 120);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            default: out_ready <= ($urandom_range(0, 9) < 3);
        endcase
    end

    // Present one input word, with a random gap at the start of each burst
    task automatic send_word(input in_word_t w, input bit pinned, input bit has,
                             input out_word_t res);
        int unsigned gap;
        pin_t        pin;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        pin.pinned = pinned;
        pin.has    = has;
        pin.word   = res;
        pin_q.push_back(pin);
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
    endtask

    // Drop valid and wait until every expected word has come out
    task automatic settle_pipeline();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_root(input logic [PPN_W-1:0] value);
        settle_pipeline();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic in_word_t rand_word(input logic cmd);
        in_word_t w;
        w.cmd       = cmd;
        w.virt_addr = VA_W'({$urandom, $urandom});
        w.mem_data  = {$urandom, $urandom};
        return w;
    endfunction

    function automatic stim_row_t word_row(input logic cmd, input logic [VA_W-1:0] va,
                                           input logic [PTE_W-1:0] pte);
        stim_row_t r;
        r.is_cfg         = 1'b0;
        r.cfg_value      = '0;
        r.word.cmd       = cmd;
        r.word.virt_addr = va;
        r.word.mem_data  = pte;
        r.pinned         = 1'b0;
        r.pin_has        = 1'b0;
        r.pin_word       = '0;
        return r;
    endfunction

    function automatic stim_row_t pinned_row(input logic cmd, input logic [VA_W-1:0] va,
                                             input logic [PTE_W-1:0] pte, input bit has,
                                             input out_word_t res);
        stim_row_t r;
        r          = word_row(cmd, va, pte);
        r.pinned   = 1'b1;
        r.pin_has  = has;
        r.pin_word = res;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input logic [PPN_W-1:0] value);
        stim_row_t r;
        r           = word_row(CMD_TRANSLATE, '0, '0);
        r.is_cfg    = 1'b1;
        r.cfg_value = value;
        return r;
    endfunction

    function automatic out_word_t read_word(input logic [PA_W-1:0] addr);
        out_word_t o;
        o           = '0;
        o.out_kind  = KIND_READ;
        o.read_addr = addr;
        return o;
    endfunction

    function automatic out_word_t miss_word();
        out_word_t o;
        o          = '0;
        o.out_kind = KIND_DONE;
        return o;
    endfunction

    // Random walks until the phase has produced its share of result words
    task automatic run_phase(input int unsigned target);
        int unsigned goal;
        int unsigned pick;
        int unsigned depth;
        in_word_t    w;
        goal = walk_results + target;
        while (walk_results < goal)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 16)
            begin
                // Well-formed walk, mostly valid entries
                send_word(rand_word(CMD_TRANSLATE), 1'b0, 1'b0, '0);
                for (int l = 0; l < 3; l++)
                begin
                    w = rand_word(CMD_RESPONSE);
                    w.mem_data[0] = ($urandom_range(0, 9) != 0);
                    send_word(w, 1'b0, 1'b0, '0);
                    if (!w.mem_data[0])
                        break;
                end
            end
            else if (pick < 18)
                send_word(rand_word(logic'($urandom_range(0, 1))), 1'b0, 1'b0, '0);
            else
            begin
                // Cut a walk short and hit the busy walker with a new request
                send_word(rand_word(CMD_TRANSLATE), 1'b0, 1'b0, '0);
                depth = $urandom_range(0, 2);
                repeat (depth)
                begin
                    w = rand_word(CMD_RESPONSE);
                    w.mem_data[0] = 1'b1;
                    send_word(w, 1'b0, 1'b0, '0);
                end
                send_word(rand_word(CMD_TRANSLATE), 1'b0, 1'b0, '0);
            end
        end
    endtask

    initial
    begin : stimulus
        // Directed table, root starts at 0 after reset
        dir_rows.push_back(pinned_row(CMD_RESPONSE, '0, '1, 1'b0, '0));
        dir_rows.push_back(pinned_row(CMD_TRANSLATE, '0, '0, 1'b1, read_word('0)));
        dir_rows.push_back(pinned_row(CMD_TRANSLATE, '1, '0, 1'b0, '0));
        dir_rows.push_back(pinned_row(CMD_RESPONSE, '0, '0, 1'b1, miss_word()));
        dir_rows.push_back(pinned_row(CMD_TRANSLATE, '1, '0, 1'b1, read_word(56'hFF8)));
        dir_rows.push_back(word_row(CMD_RESPONSE, '0, '1));
        dir_rows.push_back(word_row(CMD_RESPONSE, '0, 64'h1));
        dir_rows.push_back(word_row(CMD_RESPONSE, '0, '1));
        dir_rows.push_back(word_row(CMD_TRANSLATE, 39'h55_5555_5555, '0));
        dir_rows.push_back(word_row(CMD_RESPONSE, '0, 64'h8000_0000_0000_0401));
        dir_rows.push_back(pinned_row(CMD_RESPONSE, '0, 64'hFFFF_FFFF_FFFF_FFFE,
                                      1'b1, miss_word()));
        dir_rows.push_back(word_row(CMD_TRANSLATE, 39'h2A_AAAA_AAAA, '0));
        dir_rows.push_back(word_row(CMD_RESPONSE, '0, 64'h0000_0000_0012_3401));
        dir_rows.push_back(word_row(CMD_RESPONSE, '0, 64'h003F_FFFF_FFFF_FC01));
        dir_rows.push_back(pinned_row(CMD_RESPONSE, '0, 64'h2, 1'b1, miss_word()));
        dir_rows.push_back(pinned_row(CMD_RESPONSE, '0, 64'h1, 1'b0, '0));
        dir_rows.push_back(cfg_row('1));
        dir_rows.push_back(word_row(CMD_TRANSLATE, '1, '0));
        dir_rows.push_back(word_row(CMD_RESPONSE, '0, 64'h1));
        dir_rows.push_back(pinned_row(CMD_TRANSLATE, '0, '0, 1'b0, '0));
        // Rewrite the root while a walk is still in flight
        dir_rows.push_back(cfg_row('0));
        dir_rows.push_back(word_row(CMD_RESPONSE, '0, 64'h5));
        dir_rows.push_back(word_row(CMD_RESPONSE, '0, '1));
        dir_rows.push_back(pinned_row(CMD_TRANSLATE, '0, '0, 1'b1, read_word('0)));
        dir_rows.push_back(pinned_row(CMD_RESPONSE, '0, '0, 1'b1, miss_word()));

        // Hold reset, then release it
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
                write_root(dir_rows[i].cfg_value);
            else
                send_word(dir_rows[i].word, dir_rows[i].pinned, dir_rows[i].pin_has,
                          dir_rows[i].pin_word);
        end

        // Random phases, one root setting each
        write_root('1);
        run_phase(WALKS_PER_PHASE);
        write_root(PPN_W'(1));
        run_phase(WALKS_PER_PHASE);
        write_root(PPN_W'({$urandom, $urandom}));
        run_phase(WALKS_PER_PHASE);
        write_root('0);
        run_phase(WALKS_PER_PHASE);
        write_root(PPN_W'({$urandom, $urandom}));
        run_phase(WALKS_PER_PHASE);
        write_root(PPN_W'($urandom_range(0, 255)));
        run_phase(WALKS_PER_PHASE);
        write_root(PPN_W'({$urandom, $urandom}));
        run_phase(WALKS_PER_PHASE);

        // Drain, then wait for stray words to show up
        settle_pipeline();
        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Stop a hung run
    initial
    begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

endmodule
